@@ src/dq_pkg.sv @@
// dq_pkg: shared types and constants of the double-ended queue unit
// no dependencies; used by every other file of the block
`default_nettype none

package dq_pkg;

    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // operation codes, the unused codes act as a query
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_dq_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_dq_cmd;

endpackage

`default_nettype wire

@@ src/dq_if.sv @@
// dq_req_if, dq_rsp_if: valid/ready channels of the double-ended queue unit
// depends on dq_pkg
`default_nettype none

interface dq_req_if;
    logic                        valid;
    logic                        ready;
    logic [dq_pkg::FUNC_W-1:0]   func;
    logic signed [dq_pkg::WORD_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface dq_rsp_if #(
    parameter int CNT_W = 5
);
    logic                               valid;
    logic                               ready;
    logic signed [dq_pkg::WORD_W-1:0]   front_value;
    logic signed [dq_pkg::WORD_W-1:0]   back_value;
    logic [CNT_W-1:0]                   item_count;
    logic                               is_empty;
    logic [dq_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output front_value, output back_value,
                    output item_count, output is_empty, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input item_count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ src/double_ended_queue_unit.sv @@
// double_ended_queue_unit: bounded deque of signed words over a ring memory
// an accepted request word passes the update, memory read and load states in turn
// a new request word waits until the last one is loaded; load stalls on a held result
// the memory write of an update must land before the registered front/back read
// reset: synchronous active-low i_rst_n empties the deque; stored words are not cleared
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dq_req_if.sink      i_req,
    dq_rsp_if.source    o_rsp
);
    import dq_pkg::*;

    // pointer and count widths follow the depth
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // command bundle from the sequencer to the datapath
    t_dq_cmd cmd;

    // sequencer: request word taken only in idle, result word held until taken
    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // datapath: ring memory with head pointer and count, result register
    // the result register frees the input side while a word waits downstream
    dq_dpath #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_req.func),
        .i_value       (i_req.value),
        .o_front_value (o_rsp.front_value),
        .o_back_value  (o_rsp.back_value),
        .o_item_count  (o_rsp.item_count),
        .o_is_empty    (o_rsp.is_empty),
        .o_status      (o_rsp.status)
    );

endmodule

`default_nettype wire

@@ src/dq_ctrl.sv @@
// dq_ctrl: sequencing state machine and result valid flag
// depends on dq_pkg
`default_nettype none

module dq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dq_pkg::t_dq_cmd     o_cmd
);
    import dq_pkg::*;

    t_dq_state r_state, n_state;
    logic      r_out_valid, n_out_valid;
    logic      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_READ: o_cmd.read = 1'b1;
            S_LOAD: o_cmd.load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ src/dq_dpath.sv @@
// dq_dpath: ring memory, head pointer, count and result registers
// depends on dq_pkg; driven by dq_ctrl commands
`default_nettype none

module dq_dpath #(
    parameter int DEPTH = 16,
    parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dq_pkg::t_dq_cmd                i_cmd,
    input  wire logic [dq_pkg::FUNC_W-1:0]      i_func,
    input  wire logic signed [dq_pkg::WORD_W-1:0] i_value,
    output logic signed [dq_pkg::WORD_W-1:0]    o_front_value,
    output logic signed [dq_pkg::WORD_W-1:0]    o_back_value,
    output logic [CNT_W-1:0]                    o_item_count,
    output logic                                o_is_empty,
    output logic [dq_pkg::STATUS_W-1:0]         o_status
);
    import dq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [FUNC_W-1:0] r_func;
    logic [WORD_W-1:0] r_value;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_front_rd, r_back_rd;

    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  back_addr;
    logic              is_full, is_empty;

    logic signed [WORD_W-1:0] r_o_front, r_o_back;
    logic [CNT_W-1:0]         r_o_count;
    logic                     r_o_empty;
    logic [STATUS_W-1:0]      r_o_status;

    // ring add of two in-range offsets, result stays below twice the depth
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W) sum = sum - DEPTH_W;
        return sum[PTR_W-1:0];
    endfunction

    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = ring_add(r_head, r_count[PTR_W-1:0]);
        case (t_op'(r_func))
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_head  = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
                    wr_addr = n_head;
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    // count minus one wraps when empty; that read is masked at load
    assign back_addr = ring_add(r_head, PTR_W'(r_count - 1'b1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_cmd.read) begin
            r_front_rd <= mem[r_head];
            r_back_rd  <= mem[back_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.load) begin
            r_o_front  <= is_empty ? EMPTY_WORD : r_front_rd;
            r_o_back   <= is_empty ? EMPTY_WORD : r_back_rd;
            r_o_count  <= r_count;
            r_o_empty  <= is_empty;
            r_o_status <= r_status;
        end
    end

    assign o_front_value = r_o_front;
    assign o_back_value  = r_o_back;
    assign o_item_count  = r_o_count;
    assign o_is_empty    = r_o_empty;
    assign o_status      = r_o_status;

endmodule

`default_nettype wire

@@ src/dq_checker.sv @@
// dq_checker: port-level assertions of the double-ended queue unit
// depends on dq_pkg; bound to double_ended_queue_unit
`default_nettype none

module dq_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_req_valid,
    input wire logic                              i_req_ready,
    input wire logic                              i_rsp_valid,
    input wire logic                              i_rsp_ready,
    input wire logic [dq_pkg::WORD_W-1:0]         i_rsp_front,
    input wire logic [dq_pkg::WORD_W-1:0]         i_rsp_back,
    input wire logic [CNT_W-1:0]                  i_rsp_count,
    input wire logic                              i_rsp_empty,
    input wire logic [dq_pkg::STATUS_W-1:0]       i_rsp_status
);
    import dq_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_front)
            && $stable(i_rsp_back) && $stable(i_rsp_count) && $stable(i_rsp_status))
        else $error("result word changed while stalled");

    // one request word at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one in flight");

    // empty result shows all ones and zero count
    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_empty == (i_rsp_count == '0))
            && (!i_rsp_empty || (i_rsp_front == EMPTY_WORD && i_rsp_back == EMPTY_WORD)))
        else $error("empty flag, count and end words disagree");

    // underflow only on an empty deque
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_UNDERFLOW |-> i_rsp_empty)
        else $error("underflow reported on a non-empty deque");

    // overflow only on a full deque
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_OVERFLOW |-> i_rsp_count == CNT_W'(DEPTH))
        else $error("overflow reported on a deque that is not full");

endmodule

bind double_ended_queue_unit dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_front  (o_rsp.front_value),
    .i_rsp_back   (o_rsp.back_value),
    .i_rsp_count  (o_rsp.item_count),
    .i_rsp_empty  (o_rsp.is_empty),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
